// ----- rtl/epnm_pkg.sv -----
`default_nettype none
package epnm_pkg;

   // Score and yaw constants.
   localparam int SCORE_W        = 20;
   localparam int SCORE_BIT_W    = 5;
   localparam int YAW_LIMIT      = 99;
   localparam int YAW_SLOTS      = 2 * YAW_LIMIT + 1;
   localparam int YIDX_W         = 8;
   localparam logic [SCORE_W-1:0] MISMATCH_SCORE = 20'd1000000;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANK  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BISECT,
      S_BDRAIN,
      S_BSTEP,
      S_VOTE,
      S_VDRAIN,
      S_VWAIT,
      S_FINISH
   } state_type;

   typedef struct packed {
      op_type            opcode;
      logic [11:0]       eye_left;
      logic [11:0]       eye_right;
      logic signed [7:0] label_yaw;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic signed [7:0] yaw_estimate;
      logic [19:0]       chosen_score;
      logic [8:0]        vote_count;
      logic [8:0]        entry_count;
   } rsp_type;

endpackage
`default_nettype wire

// ----- rtl/epnm_ref_mem.sv -----
`default_nettype none
module epnm_ref_mem #(
   parameter int DEPTH  = 256,
   parameter int DATA_W = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Single write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/epnm_vote.sv -----
`default_nettype none
module epnm_vote #(
   parameter int CNT_W = 9
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        clear,
   input  wire logic                        hit,
   input  wire logic [epnm_pkg::YIDX_W-1:0] hit_idx,
   output logic      [CNT_W-1:0]            best_cnt,
   output logic      [epnm_pkg::YIDX_W-1:0] best_idx
);
   import epnm_pkg::*;

   logic [CNT_W-1:0]  hist [YAW_SLOTS];
   logic [YAW_SLOTS-1:0] seen_ff;
   logic [CNT_W-1:0]  rd_q_ff;
   logic              rd_seen_ff;
   logic              hit1_ff;
   logic [YIDX_W-1:0] idx1_ff;
   logic              fwd_vld_ff;
   logic [YIDX_W-1:0] fwd_idx_ff;
   logic [CNT_W-1:0]  fwd_val_ff;
   logic [CNT_W-1:0]  best_cnt_ff;
   logic [YIDX_W-1:0] best_idx_ff;
   logic [CNT_W-1:0]  old_cnt;
   logic [CNT_W-1:0]  new_cnt;

   // Stage two: pick the forwarded count when the previous item wrote the same slot.
   always_comb begin
      if (fwd_vld_ff && (fwd_idx_ff == idx1_ff)) begin
         old_cnt = fwd_val_ff;
      end else if (rd_seen_ff) begin
         old_cnt = rd_q_ff;
      end else begin
         old_cnt = '0;
      end
      new_cnt = old_cnt + CNT_W'(1);
   end

   // Histogram memory: read in stage one, write back in stage two.
   always_ff @(posedge clock) begin
      rd_q_ff    <= hist[hit_idx];
      rd_seen_ff <= seen_ff[hit_idx];
      idx1_ff    <= hit_idx;
      if (hit1_ff) begin
         hist[idx1_ff] <= new_cnt;
      end
      fwd_idx_ff <= idx1_ff;
      fwd_val_ff <= new_cnt;
   end

   // Control state: slot valid bits, pipeline flags and the running winner.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         seen_ff     <= '0;
         hit1_ff     <= 1'b0;
         fwd_vld_ff  <= 1'b0;
         best_cnt_ff <= '0;
         best_idx_ff <= '0;
      end else begin
         hit1_ff    <= hit;
         fwd_vld_ff <= hit1_ff;
         if (hit1_ff) begin
            seen_ff[idx1_ff] <= 1'b1;
            if ((new_cnt > best_cnt_ff) ||
                ((new_cnt == best_cnt_ff) && (idx1_ff < best_idx_ff))) begin
               best_cnt_ff <= new_cnt;
               best_idx_ff <= idx1_ff;
            end
         end
      end
   end

   assign best_cnt = best_cnt_ff;
   assign best_idx = best_idx_ff;

endmodule
`default_nettype wire

// ----- rtl/eye_position_nearest_match_vote.sv -----
`default_nettype none
// Channel   Direction  Ports                        Carries
// req       in         req_valid/req_ready/req_item  one command item
// rsp       out        rsp_valid/rsp_ready/rsp_item  one result item per command
// csr       in         csr_valid/csr_ready/csr_data  rank_select register
//
// Clear, append and no-op items go from idle straight to the finish state. A query
// runs a bisection over the 20-bit score, one table pass per bit through the
// single read port, then one voting pass.
// Reset is synchronous; the table contents stay undefined until appended.
// A finished result waits in the output register while rsp_ready is low.
module eye_position_nearest_match_vote #(
   parameter int TABLE_DEPTH = 256,
   parameter int COORD_BITS  = 12
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire epnm_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output epnm_pkg::rsp_type      rsp_item,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [7:0]        csr_data
);
   import epnm_pkg::*;

   localparam int AW     = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int DATA_W = 2 * COORD_BITS + 8;
   localparam int SUM_W  = COORD_BITS + 1;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [7:0]          rank_ff, rank_in;
   logic [COORD_BITS-1:0] ql_ff, ql_in, qr_ff, qr_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic                rvld_ff, rvld_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SCORE_W-1:0]  cur_ff, cur_in;
   logic [SCORE_BIT_W-1:0] bit_ff, bit_in;
   status_type          stat_ff, stat_in;
   logic                qok_ff, qok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                tw_en;
   logic [DATA_W-1:0]   tw_data;
   logic [DATA_W-1:0]   rd_data;
   logic                vclr;
   logic                hit;
   logic [CNT_W-1:0]    best_cnt;
   logic [YIDX_W-1:0]   best_idx;

   logic [31:0]         el_wide, er_wide, fill_wide, rank_wide, cnt_wide, votes_wide;
   logic [COORD_BITS-1:0] req_l, req_r, ent_l, ent_r;
   logic signed [7:0]   ent_yaw, sat_yaw;
   logic [8:0]          yaw_sum;
   logic [SUM_W-1:0]    qsum, esum;
   logic [SCORE_W-1:0]  score, trial, bit_mask;
   logic                last_idx;

   // Input coordinates reduced to the configured width.
   assign el_wide = 32'(req_item.eye_left);
   assign er_wide = 32'(req_item.eye_right);
   assign req_l   = el_wide[COORD_BITS-1:0];
   assign req_r   = er_wide[COORD_BITS-1:0];

   // Yaw label clamped to the supported range before it is stored.
   always_comb begin
      if (req_item.label_yaw > 8'sd99) begin
         sat_yaw = 8'sd99;
      end else if (req_item.label_yaw < -8'sd99) begin
         sat_yaw = -8'sd99;
      end else begin
         sat_yaw = req_item.label_yaw;
      end
   end

   assign tw_data = {sat_yaw, req_r, req_l};

   // Score of the entry returned by the table against the held query.
   assign ent_l   = rd_data[COORD_BITS-1:0];
   assign ent_r   = rd_data[2*COORD_BITS-1:COORD_BITS];
   assign ent_yaw = rd_data[DATA_W-1:2*COORD_BITS];
   assign qsum    = SUM_W'(ql_ff) + SUM_W'(qr_ff);
   assign esum    = SUM_W'(ent_l) + SUM_W'(ent_r);

   always_comb begin
      if (((ql_ff != '0) != (ent_l != '0)) || ((qr_ff != '0) != (ent_r != '0))) begin
         score = MISMATCH_SCORE;
      end else if ((ql_ff == '0) && (qr_ff == '0)) begin
         score = '0;
      end else if (qsum >= esum) begin
         score = SCORE_W'(qsum - esum);
      end else begin
         score = SCORE_W'(esum - qsum);
      end
   end

   // Bisection trial value: the bits decided so far with all lower bits set.
   assign bit_mask = SCORE_W'(1) << bit_ff;
   assign trial    = cur_ff | (bit_mask - SCORE_W'(1));
   assign last_idx = (CNT_W'(idx_ff) == (fill_ff - CNT_W'(1)));

   assign fill_wide = 32'(fill_ff);
   assign rank_wide = 32'(rank_ff);
   assign cnt_wide  = 32'(cnt_ff);
   assign votes_wide = 32'(best_cnt);

   assign hit     = rvld_ff && (score == cur_ff) &&
                    ((state_ff == S_VOTE) || (state_ff == S_VDRAIN));
   assign yaw_sum = 9'($signed(ent_yaw) + 9'sd99);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if ((req_item.opcode == OP_QUERY) && (fill_ff != '0) &&
                   (rank_wide < fill_wide)) begin
                  state_in = S_BISECT;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_BISECT: if (last_idx) state_in = S_BDRAIN;
         S_BDRAIN: state_in = S_BSTEP;
         S_BSTEP: begin
            if (bit_ff == '0) begin
               state_in = S_VOTE;
            end else begin
               state_in = S_BISECT;
            end
         end
         S_VOTE:   if (last_idx) state_in = S_VDRAIN;
         S_VDRAIN: state_in = S_VWAIT;
         S_VWAIT:  state_in = S_FINISH;
         S_FINISH: if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Datapath and control outputs.
   always_comb begin
      fill_in      = fill_ff;
      rank_in      = rank_ff;
      ql_in        = ql_ff;
      qr_in        = qr_ff;
      idx_in       = idx_ff;
      rvld_in      = 1'b0;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      bit_in       = bit_ff;
      stat_in      = stat_ff;
      qok_in       = qok_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      tw_en        = 1'b0;
      vclr         = 1'b0;

      if (csr_valid) begin
         rank_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               stat_in = ST_OK;
               qok_in  = 1'b0;
               unique case (req_item.opcode)
                  OP_CLEAR: fill_in = '0;
                  OP_APPEND: begin
                     if (fill_wide >= 32'(TABLE_DEPTH)) begin
                        stat_in = ST_FULL;
                     end else begin
                        tw_en   = 1'b1;
                        fill_in = fill_ff + CNT_W'(1);
                     end
                  end
                  OP_QUERY: begin
                     vclr   = 1'b1;
                     ql_in  = req_l;
                     qr_in  = req_r;
                     idx_in = '0;
                     cnt_in = '0;
                     cur_in = '0;
                     bit_in = SCORE_BIT_W'(SCORE_W - 1);
                     if (fill_ff == '0) begin
                        stat_in = ST_EMPTY;
                     end else if (rank_wide >= fill_wide) begin
                        stat_in = ST_RANK;
                     end else begin
                        qok_in = 1'b1;
                     end
                  end
                  OP_NOP: ;
                  default: ;
               endcase
            end
         end
         S_BISECT, S_BDRAIN: begin
            if (state_ff == S_BISECT) begin
               rvld_in = 1'b1;
               idx_in  = idx_ff + AW'(1);
            end
            if (rvld_ff && (score <= trial)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_BSTEP: begin
            // Too few scores at or below the trial: this bit of the answer is one.
            if (cnt_wide <= rank_wide) begin
               cur_in = cur_ff | bit_mask;
            end
            idx_in = '0;
            cnt_in = '0;
            if (bit_ff != '0) begin
               bit_in = bit_ff - SCORE_BIT_W'(1);
            end
         end
         S_VOTE: begin
            rvld_in = 1'b1;
            idx_in  = idx_ff + AW'(1);
         end
         S_VDRAIN, S_VWAIT: ;
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = stat_ff;
               rsp_in.entry_count   = fill_wide[8:0];
               if (qok_ff) begin
                  rsp_in.yaw_estimate = $signed(best_idx) - 8'sd99;
                  rsp_in.chosen_score = cur_ff;
                  rsp_in.vote_count   = votes_wide[8:0];
               end else begin
                  rsp_in.yaw_estimate = '0;
                  rsp_in.chosen_score = '0;
                  rsp_in.vote_count   = '0;
               end
            end
         end
         default: ;
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rank_ff      <= '0;
         rvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rank_ff      <= rank_in;
         rvld_ff      <= rvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ql_ff   <= ql_in;
      qr_ff   <= qr_in;
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      cur_ff  <= cur_in;
      bit_ff  <= bit_in;
      stat_ff <= stat_in;
      qok_ff  <= qok_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Reference table.
   epnm_ref_mem #(
      .DEPTH  (TABLE_DEPTH),
      .DATA_W (DATA_W)
   ) u_ref_mem (
      .clock   (clock),
      .wr_en   (tw_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (tw_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Yaw histogram and winner tracking.
   epnm_vote #(
      .CNT_W (CNT_W)
   ) u_vote (
      .clock    (clock),
      .reset    (reset),
      .clear    (vclr),
      .hit      (hit),
      .hit_idx  (yaw_sum[YIDX_W-1:0]),
      .best_cnt (best_cnt),
      .best_idx (best_idx)
   );

endmodule
`default_nettype wire
